/* rtl/core/double_ended_stack_allocator_core_macros.svh */
// Assertion macros shared by the allocator core.
// No dependencies; include by bare file name inside a module body.
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_CORE_MACROS_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DESA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DESA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/desa_pkg.sv */
// Types and constants for the double-ended stack allocator core.
// No dependencies.
package desa_pkg;

    localparam int unsigned SZ_W   = 31;
    localparam int unsigned ADDR_W = 32;

    typedef enum logic [2:0] {
        KIND_PERM_ALLOC  = 3'd0,
        KIND_TEMP_ALLOC  = 3'd1,
        KIND_TEMP_FREE   = 3'd2,
        KIND_CLEAR_TEMPS = 3'd3,
        KIND_SET_MARK    = 3'd4,
        KIND_REWIND      = 3'd5,
        KIND_QUERY       = 3'd6,
        KIND_CLEAR_ALL   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_LAST = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PREF_ANY  = 2'd0,
        PREF_LOW  = 2'd1,
        PREF_HIGH = 2'd2
    } t_pref;

    // Register indexes on the configuration port
    localparam logic REG_TOTAL_SIZE   = 1'b0;
    localparam logic REG_BASE_ADDRESS = 1'b1;

    localparam logic [SZ_W-1:0] TOTAL_SIZE_RESET = 31'h0400_0000;

    // ends_swapped = 1: permanent end is the high end
    typedef struct packed {
        logic            ends_swapped;
        logic [SZ_W-1:0] low_mark;
        logic [SZ_W-1:0] low_perm;
        logic [SZ_W-1:0] low_temp;
        logic [SZ_W-1:0] low_hw;
        logic [SZ_W-1:0] high_mark;
        logic [SZ_W-1:0] high_perm;
        logic [SZ_W-1:0] high_temp;
        logic [SZ_W-1:0] high_hw;
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] granted;
    } t_result;

endpackage

/* rtl/core/desa_exec.sv */
// Single-pass operation logic: next allocator state and result for one item.
// Depends on desa_pkg.
module desa_exec
    import desa_pkg::*;
(
    input  t_state            i_state,
    input  t_kind             i_kind,
    input  logic [SZ_W-1:0]   i_req,
    input  logic [1:0]        i_pref,
    input  logic [ADDR_W-1:0] i_faddr,
    input  logic [SZ_W-1:0]   i_total,
    input  logic [ADDR_W-1:0] i_base,
    output t_state            o_state,
    output t_result           o_result
);

    logic              es;
    logic [SZ_W-1:0]   perm_p, perm_t, temp_t, hw_p, hw_t;
    logic signed [32:0] d_t, d_p;
    logic              can_swap, swapped_es, do_try, es1;
    logic [31:0]       size_p, size_t;
    logic [33:0]       need_p, need_t;
    logic              fit_p, fit_t;
    logic [SZ_W-1:0]   lp_new, hp_new;
    logic [SZ_W-1:0]   perm_p1, temp_t1, hw_t1, temp_new;
    logic [ADDR_W-1:0] start_addr;
    logic [SZ_W-1:0]   perm_t0, temp_t0, temp_free;
    logic [ADDR_W-1:0] hdr, expect_hdr;
    logic              free_bad;

    always_comb begin
        es     = i_state.ends_swapped;
        perm_p = es ? i_state.high_perm : i_state.low_perm;
        hw_p   = es ? i_state.high_hw   : i_state.low_hw;
        perm_t = es ? i_state.low_perm  : i_state.high_perm;
        temp_t = es ? i_state.low_temp  : i_state.high_temp;
        hw_t   = es ? i_state.low_hw    : i_state.high_hw;

        // Swap when the temp end is empty and has more unused high-water
        d_t        = $signed({2'b00, hw_t}) - $signed({2'b00, perm_t});
        d_p        = $signed({2'b00, hw_p}) - $signed({2'b00, perm_p});
        can_swap   = (temp_t == perm_t) && (d_t > d_p);
        swapped_es = can_swap ? ~es : es;

        do_try = (i_pref == PREF_ANY) || ((i_pref == PREF_HIGH) && !es)
              || ((i_pref == PREF_LOW) && es);
        if (i_kind == KIND_TEMP_ALLOC) begin
            es1 = swapped_es;
        end else if (i_kind == KIND_PERM_ALLOC && do_try) begin
            es1 = swapped_es;
        end else begin
            es1 = es;
        end

        size_p = ({1'b0, i_req} + 32'd31) & ~32'd31;
        size_t = ({1'b0, i_req} + 32'd11) & ~32'd3;

        // Permanent allocation on end es1
        need_p = {3'b000, i_state.low_temp} + {3'b000, i_state.high_temp}
               + {2'b00, size_p};
        fit_p  = need_p <= {3'b000, i_total};
        lp_new = i_state.low_perm + size_p[SZ_W-1:0];
        hp_new = i_state.high_perm + size_p[SZ_W-1:0];

        // Temporary allocation on end ~es1
        perm_p1  = es1 ? i_state.high_perm : i_state.low_perm;
        temp_t1  = es1 ? i_state.low_temp  : i_state.high_temp;
        hw_t1    = es1 ? i_state.low_hw    : i_state.high_hw;
        need_t   = {3'b000, perm_p1} + {3'b000, temp_t1} + {2'b00, size_t};
        fit_t    = need_t <= {3'b000, i_total};
        temp_new = temp_t1 + size_t[SZ_W-1:0];
        if (es1) begin
            start_addr = i_base + {1'b0, i_state.low_temp};
        end else begin
            start_addr = i_base + {1'b0, i_total} - {1'b0, temp_new};
        end

        // Free on temp end ~es, last block only
        perm_t0 = es ? i_state.low_perm : i_state.high_perm;
        temp_t0 = es ? i_state.low_temp : i_state.high_temp;
        hdr     = i_faddr - 32'd8;
        if (es) begin
            expect_hdr = i_base + {1'b0, i_state.low_temp} - size_t;
        end else begin
            expect_hdr = i_base + {1'b0, i_total} - {1'b0, i_state.high_temp};
        end
        free_bad  = (hdr != expect_hdr) || (temp_t0 < perm_t0)
                 || (size_t > {1'b0, temp_t0 - perm_t0});
        temp_free = temp_t0 - size_t[SZ_W-1:0];

        o_state          = i_state;
        o_result.status  = ST_OK;
        o_result.granted = '0;

        unique case (i_kind)
            KIND_PERM_ALLOC: begin
                o_state.ends_swapped = es1;
                if (!fit_p) begin
                    o_result.status = ST_NO_SPACE;
                end else if (!es1) begin
                    o_result.granted  = i_base + {1'b0, i_state.low_perm};
                    o_state.low_perm  = lp_new;
                    o_state.low_temp  = lp_new;
                end else begin
                    o_result.granted  = i_base + {1'b0, i_total} - {1'b0, hp_new};
                    o_state.high_perm = hp_new;
                    o_state.high_temp = hp_new;
                end
            end
            KIND_TEMP_ALLOC: begin
                o_state.ends_swapped = es1;
                if (!fit_t) begin
                    o_result.status = ST_NO_SPACE;
                end else begin
                    o_result.granted = start_addr + 32'd8;
                    if (es1) begin
                        o_state.low_temp = temp_new;
                        if (temp_new > hw_t1) o_state.low_hw = temp_new;
                    end else begin
                        o_state.high_temp = temp_new;
                        if (temp_new > hw_t1) o_state.high_hw = temp_new;
                    end
                end
            end
            KIND_TEMP_FREE: begin
                if (free_bad) begin
                    o_result.status = ST_NOT_LAST;
                end else if (es) begin
                    o_state.low_temp = temp_free;
                end else begin
                    o_state.high_temp = temp_free;
                end
            end
            KIND_CLEAR_TEMPS: begin
                if (es) o_state.low_temp  = i_state.low_perm;
                else    o_state.high_temp = i_state.high_perm;
            end
            KIND_SET_MARK: begin
                o_state.low_mark  = i_state.low_perm;
                o_state.high_mark = i_state.high_perm;
            end
            KIND_REWIND: begin
                o_state.low_perm  = i_state.low_mark;
                o_state.low_temp  = i_state.low_mark;
                o_state.high_perm = i_state.high_mark;
                o_state.high_temp = i_state.high_mark;
            end
            KIND_QUERY: begin
                o_state = i_state;
            end
            KIND_CLEAR_ALL: begin
                o_state = '0;
            end
        endcase
    end

endmodule

/* rtl/core/double_ended_stack_allocator_core.sv */
// Double-ended stack allocator core: top level with stream channels and APB registers.
// Depends on desa_pkg, desa_exec and double_ended_stack_allocator_core_macros.svh.
//
// Usage:
//  - Requests enter on the s_axis channel (kind in tuser), one result item
//    per request leaves on the m_axis channel (status in tuser).
//  - An accepted item lands in an input register; once the result register
//    is free or being emptied, the allocator logic runs in one pass, updates
//    the end pointers and loads the result register.
//  - Throughput is one item per cycle while the receiver takes results: the
//    single-pass update of the state registers sets the rate, and the next
//    item sees the updated state.
//  - bytes_remaining and marks_present are formed from the committed state,
//    which only moves when the result register is reloaded.
//  - When the receiver stalls, the result is held, the input register holds
//    one more item, and s_axis_tready drops.
//  - Synchronous reset clears all pointers, marks and the swap bit, sets
//    total_size to 64 MiB and base_address to zero, and empties both stages.
//  - Write total_size (offset 0) and base_address (offset 4) only while idle.
module double_ended_stack_allocator_core
    import desa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [30:0] request_bytes, [32:31] end_preference, [64:33] free_address, [71:65] zero
    input  logic [71:0] s_axis_tdata,
    // [2:0] kind
    input  logic [2:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] granted_address, [62:32] bytes_remaining, [63] marks_present
    output logic [63:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    logic              r_in_vld, n_in_vld;
    t_kind             r_in_kind;
    logic [SZ_W-1:0]   r_in_req;
    logic [1:0]        r_in_pref;
    logic [ADDR_W-1:0] r_in_faddr;
    logic              r_out_vld, n_out_vld;
    t_result           r_out;
    t_state            r_state;
    logic [SZ_W-1:0]   r_total;
    logic [ADDR_W-1:0] r_base;

    t_state            n_state;
    t_result           n_out;
    logic              fire, in_take, cfg_wr;
    logic [SZ_W-1:0]   lo_used, hi_used, remaining;
    logic [SZ_W:0]     used;

    desa_exec u_exec (
        .i_state  (r_state),
        .i_kind   (r_in_kind),
        .i_req    (r_in_req),
        .i_pref   (r_in_pref),
        .i_faddr  (r_in_faddr),
        .i_total  (r_total),
        .i_base   (r_base),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Execute when the result slot is free or being emptied
    assign fire          = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign n_in_vld      = in_take || (r_in_vld && !fire);
    assign n_out_vld     = fire || (r_out_vld && !m_axis_tready);

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_TOTAL_SIZE:   prdata = {1'b0, r_total};
            REG_BASE_ADDRESS: prdata = r_base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
            r_total   <= TOTAL_SIZE_RESET;
            r_base    <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (fire) r_state <= n_state;
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_TOTAL_SIZE:   r_total <= pwdata[SZ_W-1:0];
                    REG_BASE_ADDRESS: r_base  <= pwdata;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind  <= t_kind'(s_axis_tuser);
            r_in_req   <= s_axis_tdata[30:0];
            r_in_pref  <= s_axis_tdata[32:31];
            r_in_faddr <= s_axis_tdata[64:33];
        end
        if (fire) r_out <= n_out;
    end

    // Space left after the item in the result register
    always_comb begin
        lo_used = (r_state.low_perm > r_state.low_temp) ? r_state.low_perm
                                                        : r_state.low_temp;
        hi_used = (r_state.high_perm > r_state.high_temp) ? r_state.high_perm
                                                          : r_state.high_temp;
        used    = {1'b0, lo_used} + {1'b0, hi_used};
        if (used >= {1'b0, r_total}) begin
            remaining = '0;
        end else begin
            remaining = r_total - used[SZ_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {(r_state.low_mark != '0) || (r_state.high_mark != '0),
                            remaining, r_out.granted};

    `include "double_ended_stack_allocator_core_macros.svh"

    `DESA_ASSERT_NEXT(a_clear_all_zeroes, i_clk, i_rst_n, fire && (r_in_kind == KIND_CLEAR_ALL), r_state == '0, "clear all left state behind")
    `DESA_ASSERT_NEXT(a_no_item_lost, i_clk, i_rst_n, r_in_vld && !fire, r_in_vld, "pending item dropped")
    `DESA_ASSERT_NOW(a_fail_no_grant, i_clk, i_rst_n, r_out_vld && (r_out.status != ST_OK), r_out.granted == '0, "address granted on a failed item")
    `DESA_ASSERT_NEXT(a_fail_keeps_perm, i_clk, i_rst_n, fire && (n_out.status != ST_OK), (r_state.low_perm == $past(r_state.low_perm)) && (r_state.high_perm == $past(r_state.high_perm)), "failed item moved permanent tops")

endmodule

/* verif/double_ended_stack_allocator_core_tb.sv */
// Self-checking testbench for the double-ended stack allocator core.
// Depends on desa_pkg and the core RTL; drives the request stream and APB, checks the result stream.
`timescale 1ns / 1ps

module double_ended_stack_allocator_core_tb;
    import desa_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned IDLE_PCT     = 26;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam logic [1:0]  PREF_NONE    = 2'd3;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] req;
        logic [1:0]  pref;
        logic [31:0] faddr;
    } alloc_req_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] granted;
        logic [30:0] remaining;
        logic        marks;
    } alloc_res_t;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] req;
        logic [1:0]  pref;
        logic [31:0] faddr;
        logic        use_top;
        logic        typed;
        alloc_res_t  want;
    } step_row_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [30:0] req;
    } live_temp_t;

    localparam alloc_res_t UNTYPED = '0;

    // Rows marked typed carry a hand-written result; the rest rely on the predictor.
    localparam step_row_t DIRECTED [23] = '{
        '{KIND_QUERY,       31'd0,          PREF_ANY,  32'd0, 1'b0, 1'b1,
          '{ST_OK, 32'd0, TOTAL_SIZE_RESET, 1'b0}},
        '{KIND_PERM_ALLOC,  31'h7FFF_FFFF,  PREF_ANY,  32'd0, 1'b0, 1'b1,
          '{ST_NO_SPACE, 32'd0, TOTAL_SIZE_RESET, 1'b0}},
        '{KIND_TEMP_ALLOC,  31'h7FFF_FFFF,  PREF_ANY,  32'd0, 1'b0, 1'b1,
          '{ST_NO_SPACE, 32'd0, TOTAL_SIZE_RESET, 1'b0}},
        '{KIND_TEMP_FREE,   31'd0,          PREF_ANY,  32'd0, 1'b0, 1'b1,
          '{ST_NOT_LAST, 32'd0, TOTAL_SIZE_RESET, 1'b0}},
        '{KIND_PERM_ALLOC,  31'd1,          PREF_LOW,  32'd0, 1'b0, 1'b1,
          '{ST_OK, 32'd0, TOTAL_SIZE_RESET - 31'd32, 1'b0}},
        '{KIND_PERM_ALLOC,  31'd32,         PREF_NONE, 32'd0, 1'b0, 1'b1,
          '{ST_OK, 32'd32, TOTAL_SIZE_RESET - 31'd64, 1'b0}},
        '{KIND_PERM_ALLOC,  31'd33,         PREF_HIGH, 32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_PERM_ALLOC,  31'd0,          PREF_LOW,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_TEMP_ALLOC,  31'd5,          PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_TEMP_ALLOC,  31'd100,        PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_TEMP_FREE,   31'd100,        PREF_ANY,  32'h1234_5678, 1'b0, 1'b0, UNTYPED},
        '{KIND_TEMP_FREE,   31'd0,          PREF_ANY,  32'd0, 1'b1, 1'b0, UNTYPED},
        '{KIND_SET_MARK,    31'd0,          PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_TEMP_ALLOC,  31'd2,          PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_PERM_ALLOC,  31'd64,         PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_CLEAR_TEMPS, 31'd0,          PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_TEMP_ALLOC,  31'd7,          PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_TEMP_FREE,   31'd0,          PREF_ANY,  32'd0, 1'b1, 1'b0, UNTYPED},
        '{KIND_REWIND,      31'd0,          PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_QUERY,       31'd0,          PREF_ANY,  32'd0, 1'b0, 1'b0, UNTYPED},
        '{KIND_CLEAR_ALL,   31'd0,          PREF_ANY,  32'd0, 1'b0, 1'b1,
          '{ST_OK, 32'd0, TOTAL_SIZE_RESET, 1'b0}},
        '{KIND_TEMP_ALLOC,  31'd0,          PREF_ANY,  32'd0, 1'b0, 1'b1,
          '{ST_OK, 32'h0400_0000, TOTAL_SIZE_RESET - 31'd8, 1'b0}},
        '{KIND_TEMP_FREE,   31'd0,          PREF_ANY,  32'h0400_0000, 1'b0, 1'b1,
          '{ST_OK, 32'd0, TOTAL_SIZE_RESET, 1'b0}}
    };

    localparam logic [30:0] PHASE_TOTAL [5] =
        '{31'h7FFF_FFFF, 31'd0, 31'd4096, 31'd200000, 31'd1024};
    localparam logic [31:0] PHASE_BASE [5] =
        '{32'hFFFF_FFF0, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_1000};
    localparam int unsigned PHASE_ITEMS [5] = '{260, 60, 320, 300, 200};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [30:0] request_bytes, [32:31] end_preference, [64:33] free_address, [71:65] zero
    logic [71:0] s_axis_tdata;
    // [2:0] kind
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [31:0] granted_address, [62:32] bytes_remaining, [63] marks_present
    logic [63:0] m_axis_tdata;
    // [1:0] status
    logic [1:0]  m_axis_tuser;

    // Predictor copy of the allocator; index 0 is the low end, 1 the high end.
    logic [30:0] perm_top  [2];
    logic [30:0] temp_top  [2];
    logic [30:0] temp_peak [2];
    logic [30:0] mark_at   [2];
    logic        swapped;
    logic [30:0] cfg_total;
    logic [31:0] cfg_base;

    alloc_res_t  pending_results [$];
    live_temp_t  live_temps [$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned rand_cnt;
    logic        steady;
    logic        stall_now;
    logic        hold_rx;

    double_ended_stack_allocator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_error(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    // Swap ends when the temp end is empty and has more unused high-water.
    function automatic void try_swap();
        logic   p;
        logic   t;
        longint dt;
        longint dp;
        p = swapped;
        t = ~swapped;
        if (temp_top[t] == perm_top[t]) begin
            dt = longint'(temp_peak[t]) - longint'(perm_top[t]);
            dp = longint'(temp_peak[p]) - longint'(perm_top[p]);
            if (dt > dp) swapped = t;
        end
    endfunction

    function automatic alloc_res_t alloc_predict(input alloc_req_t it);
        alloc_res_t  res;
        logic [63:0] size;
        logic [63:0] used;
        logic [30:0] lo;
        logic [30:0] hi;
        logic [31:0] start;
        logic [31:0] hdr;
        logic [31:0] want;
        logic        p;
        logic        t;
        res.status  = ST_OK;
        res.granted = '0;
        case (it.kind)
            KIND_PERM_ALLOC: begin
                if (it.pref == PREF_ANY || (it.pref == PREF_HIGH && !swapped) ||
                    (it.pref == PREF_LOW && swapped)) try_swap();
                size = (64'(it.req) + 64'd31) & ~64'd31;
                if (64'(temp_top[0]) + 64'(temp_top[1]) + size > 64'(cfg_total)) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    p = swapped;
                    if (!p) begin
                        res.granted = cfg_base + 32'(perm_top[0]);
                        perm_top[0] = perm_top[0] + 31'(size);
                    end else begin
                        perm_top[1] = perm_top[1] + 31'(size);
                        res.granted = cfg_base + 32'(cfg_total) - 32'(perm_top[1]);
                    end
                    temp_top[p] = perm_top[p];
                end
            end
            KIND_TEMP_ALLOC: begin
                try_swap();
                t = ~swapped;
                size = (64'(it.req) + 64'd11) & ~64'd3;
                if (64'(perm_top[swapped]) + 64'(temp_top[t]) + size > 64'(cfg_total)) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    if (!t) begin
                        start = cfg_base + 32'(temp_top[0]);
                        temp_top[0] = temp_top[0] + 31'(size);
                    end else begin
                        temp_top[1] = temp_top[1] + 31'(size);
                        start = cfg_base + 32'(cfg_total) - 32'(temp_top[1]);
                    end
                    if (temp_top[t] > temp_peak[t]) temp_peak[t] = temp_top[t];
                    res.granted = start + 32'd8;
                end
            end
            KIND_TEMP_FREE: begin
                size = (64'(it.req) + 64'd11) & ~64'd3;
                t = ~swapped;
                hdr = it.faddr - 32'd8;
                if (!t) want = cfg_base + 32'(temp_top[0]) - 32'(size);
                else want = cfg_base + 32'(cfg_total) - 32'(temp_top[1]);
                if (hdr != want || temp_top[t] < perm_top[t] ||
                    size > 64'(temp_top[t] - perm_top[t])) begin
                    res.status = ST_NOT_LAST;
                end else begin
                    temp_top[t] = temp_top[t] - 31'(size);
                end
            end
            KIND_CLEAR_TEMPS: begin
                temp_top[~swapped] = perm_top[~swapped];
            end
            KIND_SET_MARK: begin
                mark_at[0] = perm_top[0];
                mark_at[1] = perm_top[1];
            end
            KIND_REWIND: begin
                perm_top[0] = mark_at[0];
                temp_top[0] = mark_at[0];
                perm_top[1] = mark_at[1];
                temp_top[1] = mark_at[1];
            end
            KIND_QUERY: begin
            end
            default: begin
                for (int e = 0; e < 2; e++) begin
                    perm_top[e]  = '0;
                    temp_top[e]  = '0;
                    temp_peak[e] = '0;
                    mark_at[e]   = '0;
                end
                swapped = 1'b0;
            end
        endcase
        lo = (perm_top[0] > temp_top[0]) ? perm_top[0] : temp_top[0];
        hi = (perm_top[1] > temp_top[1]) ? perm_top[1] : temp_top[1];
        used = 64'(lo) + 64'(hi);
        // report zero once total_size has been lowered below the space in use
        res.remaining = (used >= 64'(cfg_total)) ? '0 : 31'(64'(cfg_total) - used);
        res.marks = (mark_at[0] != '0) || (mark_at[1] != '0);
        return res;
    endfunction

    function automatic logic [30:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 31'($urandom_range(0, 200));
        if (r < 88) return 31'($urandom_range(0, cfg_total >> 3));
        if (r < 95) return 31'($urandom_range(0, cfg_total));
        return 31'($urandom());
    endfunction

    // Mostly well-formed traffic: allocs and last-in-first-out frees, with some noise.
    function automatic alloc_req_t pick_request();
        alloc_req_t  it;
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        it.req   = pick_size();
        it.pref  = 2'($urandom_range(0, 3));
        it.faddr = $urandom();
        it.kind  = KIND_QUERY;
        if (r < 28) begin
            it.kind = KIND_TEMP_ALLOC;
        end else if (r < 52) begin
            it.kind = KIND_TEMP_FREE;
            if (live_temps.size() != 0 && r < 48) begin
                k = (r < 45) ? live_temps.size() - 1 : $urandom_range(0, live_temps.size() - 1);
                it.faddr = live_temps[k].addr;
                it.req = (r < 43) ? live_temps[k].req
                                  : live_temps[k].req ^ 31'($urandom_range(1, 7));
            end
        end else if (r < 68) begin
            it.kind = KIND_PERM_ALLOC;
        end else if (r < 73) begin
            it.kind = KIND_CLEAR_TEMPS;
        end else if (r < 79) begin
            it.kind = KIND_SET_MARK;
        end else if (r < 85) begin
            it.kind = KIND_REWIND;
        end else if (r < 96) begin
            it.kind = (r < 93) ? KIND_QUERY : KIND_CLEAR_ALL;
        end else begin
            it.kind = t_kind'(3'($urandom_range(0, 7)));
        end
        return it;
    endfunction

    // Offer one item, wait for the handshake, then record what it must produce.
    task automatic offer(input alloc_req_t it, input logic typed, input alloc_res_t typed_res);
        alloc_res_t res;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, it.faddr, it.pref, it.req};
        s_axis_tuser  <= it.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = alloc_predict(it);
        pending_results.push_back(typed ? typed_res : res);
        if (res.status == ST_OK) begin
            case (it.kind)
                KIND_TEMP_ALLOC: live_temps.push_back('{res.granted, it.req});
                KIND_TEMP_FREE: if (live_temps.size() != 0) void'(live_temps.pop_back());
                KIND_CLEAR_TEMPS, KIND_REWIND, KIND_CLEAR_ALL: live_temps.delete();
                default: begin
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_TOTAL_SIZE) cfg_total = value[30:0];
        else cfg_base = value;
        // addresses move with base_address, high-end ones also with total_size; drop the free list
        live_temps.delete();
        @(posedge i_clk);
    endtask

    task automatic check_result();
        alloc_res_t want;
        if (pending_results.size() == 0) begin
            report_error("result item with nothing expected");
            return;
        end
        want = pending_results.pop_front();
        if (m_axis_tuser != want.status)
            report_error($sformatf("status got %0d want %0d", m_axis_tuser, want.status));
        if (m_axis_tdata[31:0] != want.granted)
            report_error($sformatf("granted_address got %0h want %0h",
                                   m_axis_tdata[31:0], want.granted));
        if (m_axis_tdata[62:32] != want.remaining)
            report_error($sformatf("bytes_remaining got %0d want %0d",
                                   m_axis_tdata[62:32], want.remaining));
        if (m_axis_tdata[63] != want.marks)
            report_error($sformatf("marks_present got %0d want %0d",
                                   m_axis_tdata[63], want.marks));
    endtask

    // Receiver: check on handshake, then pick the next ready value.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
            if (hold_rx) m_axis_tready <= 1'b0;
            else if (steady) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Long receiver hold-off so the block fills up and drops s_axis_tready.
    initial begin
        hold_rx = 1'b0;
        wait (stall_now);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        alloc_req_t it;
        step_row_t  row;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_QUERY;
        error_count   = 0;
        rand_cnt      = 0;
        steady        = 1'b0;
        stall_now     = 1'b0;
        cfg_total     = TOTAL_SIZE_RESET;
        cfg_base      = '0;
        swapped       = 1'b0;
        for (int e = 0; e < 2; e++) begin
            perm_top[e]  = '0;
            temp_top[e]  = '0;
            temp_peak[e] = '0;
            mark_at[e]   = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            it.kind  = row.kind;
            it.req   = row.req;
            it.pref  = row.pref;
            it.faddr = row.faddr;
            // free the most recent temp block
            if (row.use_top && live_temps.size() != 0) begin
                it.faddr = live_temps[$].addr;
                it.req   = live_temps[$].req;
            end
            offer(it, row.typed, row.want);
        end

        // State carries across phases so a lowered total_size meets space in use.
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            apb_write(REG_TOTAL_SIZE, {1'b0, PHASE_TOTAL[ph]});
            apb_write(REG_BASE_ADDRESS, (ph == 2) ? $urandom() : PHASE_BASE[ph]);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
                steady = (rand_cnt >= 120 && rand_cnt < 320);
                if (ph == 2 && n == 40) stall_now = 1'b1;
                offer(pick_request(), 1'b0, UNTYPED);
                rand_cnt++;
            end
        end

        steady = 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
